@@ src/ps2h_pkg.sv @@
// shared widths, operation codes, register indexes, reset timings, bit counts and sequencer codes of the ps2 host
`default_nettype none
package ps2h_pkg;

   localparam int OP_W    = 2;
   localparam int BYTE_W  = 8;
   localparam int TIMER_W = 24;
   localparam int PHASE_W = 4;
   localparam int COUNT_W = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [OP_W-1:0] OP_TICK = 2'd0;
   localparam logic [OP_W-1:0] OP_SEND = 2'd1;
   localparam logic [OP_W-1:0] OP_RECV = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_INHIBIT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = 2'd3;

   localparam logic [15:0]        INHIBIT_RESET = 16'd300;
   localparam logic [9:0]         HOLD_RESET    = 10'd10;
   localparam logic [9:0]         SETTLE_RESET  = 10'd50;
   localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 24'd100000;

   localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
   localparam logic [PHASE_W-1:0] PH_S_REL    = 4'd1;
   localparam logic [PHASE_W-1:0] PH_S_INH    = 4'd2;
   localparam logic [PHASE_W-1:0] PH_S_RTS    = 4'd3;
   localparam logic [PHASE_W-1:0] PH_S_WAIT   = 4'd4;
   localparam logic [PHASE_W-1:0] PH_S_BITS   = 4'd5;
   localparam logic [PHASE_W-1:0] PH_S_ACKD   = 4'd6;
   localparam logic [PHASE_W-1:0] PH_S_ACKC   = 4'd7;
   localparam logic [PHASE_W-1:0] PH_S_END    = 4'd8;
   localparam logic [PHASE_W-1:0] PH_R_SETTLE = 4'd9;
   localparam logic [PHASE_W-1:0] PH_R_WAIT   = 4'd10;
   localparam logic [PHASE_W-1:0] PH_R_HIGH   = 4'd11;
   localparam logic [PHASE_W-1:0] PH_R_BITS   = 4'd12;
   localparam logic [PHASE_W-1:0] PH_R_TAIL   = 4'd13;

   localparam logic [COUNT_W-1:0] BITS_PER_BYTE = 4'd8;
   localparam logic [COUNT_W-1:0] RX_FRAME_END  = 4'd10;

endpackage
`default_nettype wire

@@ src/ps2h_req_if.sv @@
// request channel: operation word with sampled line levels and send byte
`default_nettype none
interface ps2h_req_if;
   logic                           valid;
   logic                           ready;
   logic [ps2h_pkg::OP_W-1:0]      op;
   logic                           clock_line;
   logic                           data_line;
   logic [ps2h_pkg::BYTE_W-1:0]    send_byte;

   modport source (output valid, output op, output clock_line, output data_line,
                   output send_byte, input ready);
   modport sink   (input valid, input op, input clock_line, input data_line,
                   input send_byte, output ready);
endinterface
`default_nettype wire

@@ src/ps2h_rsp_if.sv @@
// response channel: line drives and status word of the ps2 host
`default_nettype none
interface ps2h_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           clock_drive_low;
   logic                           data_drive_low;
   logic                           received_valid;
   logic [ps2h_pkg::BYTE_W-1:0]    received_byte;
   logic                           receive_timed_out;
   logic                           send_done;
   logic                           no_device;
   logic                           busy_res;

   modport source (output valid, output clock_drive_low, output data_drive_low,
                   output received_valid, output received_byte,
                   output receive_timed_out, output send_done, output no_device,
                   output busy_res, input ready);
   modport sink   (input valid, input clock_drive_low, input data_drive_low,
                   input received_valid, input received_byte,
                   input receive_timed_out, input send_done, input no_device,
                   input busy_res, output ready);
endinterface
`default_nettype wire

@@ src/ps2_host_serial_transceiver_unit.sv @@
// ps2 host transceiver: send and receive sequencer with a registered response word
//
//  channel  dir  contents
//  req      in   op, clock_line, data_line, send_byte
//  rsp      out  clock_drive_low, data_drive_low, received_valid, received_byte,
//                receive_timed_out, send_done, no_device, busy_res
//  csr      in   csr_write_enable, csr_index, csr_write_data
//
// one word in, one word out; the response word is registered on accept
// a new word is taken every cycle while the response register is empty or being read
// rsp stall holds the response and drops req.ready; the sequencer state does not move
// reset is synchronous and returns the sequencer to idle with the default timings
`default_nettype none
module ps2_host_serial_transceiver_unit (
   input  wire                                   clock,
   input  wire                                   reset,
   ps2h_req_if.sink                              req,
   ps2h_rsp_if.source                            rsp,
   input  wire                                   csr_write_enable,
   input  wire [ps2h_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire [ps2h_pkg::CSR_DATA_W-1:0]        csr_write_data
);

   logic [15:0]                        inhibit_ff;
   logic [9:0]                         hold_ff;
   logic [9:0]                         settle_ff;
   logic [ps2h_pkg::TIMER_W-1:0]       timeout_ff;

   logic [ps2h_pkg::PHASE_W-1:0]       phase_ff, phase_in;
   logic [ps2h_pkg::TIMER_W-1:0]       timer_ff, timer_in;
   logic [ps2h_pkg::BYTE_W-1:0]        shift_ff, shift_in;
   logic [ps2h_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic                               parity_ff, parity_in;
   logic                               nodev_ff, nodev_in;
   logic                               prev_clock_ff, prev_clock_in;

   logic                               rsp_valid_ff;
   logic                               cdl_ff, cdl_in;
   logic                               ddl_ff, ddl_in;
   logic                               rv_ff, rv_in;
   logic [ps2h_pkg::BYTE_W-1:0]        rbyte_ff, rbyte_in;
   logic                               rto_ff, rto_in;
   logic                               sdone_ff, sdone_in;

   logic                               accept;
   logic                               fall;
   logic [ps2h_pkg::TIMER_W-1:0]       tick_inc;
   logic [ps2h_pkg::TIMER_W-1:0]       delay_len;
   logic                               delay_hit;
   logic [ps2h_pkg::COUNT_W-1:0]       count_inc;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         inhibit_ff <= ps2h_pkg::INHIBIT_RESET;
         hold_ff    <= ps2h_pkg::HOLD_RESET;
         settle_ff  <= ps2h_pkg::SETTLE_RESET;
         timeout_ff <= ps2h_pkg::TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            ps2h_pkg::CSR_INHIBIT: inhibit_ff <= csr_write_data[15:0];
            ps2h_pkg::CSR_HOLD:    hold_ff    <= csr_write_data[9:0];
            ps2h_pkg::CSR_SETTLE:  settle_ff  <= csr_write_data[9:0];
            ps2h_pkg::CSR_TIMEOUT: timeout_ff <= csr_write_data[ps2h_pkg::TIMER_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (phase_ff)
         ps2h_pkg::PH_S_REL,
         ps2h_pkg::PH_S_INH:    delay_len = {8'd0, inhibit_ff};
         ps2h_pkg::PH_S_RTS:    delay_len = {14'd0, hold_ff};
         ps2h_pkg::PH_R_SETTLE: delay_len = {14'd0, settle_ff};
         default:               delay_len = timeout_ff;
      endcase
   end

   assign tick_inc  = timer_ff + 24'd1;
   assign delay_hit = (tick_inc >= delay_len) || (tick_inc == '0);
   assign fall      = prev_clock_ff && !req.clock_line;
   assign count_inc = count_ff + 4'd1;

   always_comb begin
      phase_in      = phase_ff;
      timer_in      = timer_ff;
      shift_in      = shift_ff;
      count_in      = count_ff;
      parity_in     = parity_ff;
      nodev_in      = nodev_ff;
      prev_clock_in = prev_clock_ff;
      rv_in         = 1'b0;
      rbyte_in      = '0;
      rto_in        = 1'b0;
      sdone_in      = 1'b0;

      case (req.op)
         ps2h_pkg::OP_SEND: begin
            if (phase_ff == ps2h_pkg::PH_IDLE) begin
               shift_in  = req.send_byte;
               parity_in = 1'b1;
               count_in  = '0;
               timer_in  = '0;
               phase_in  = ps2h_pkg::PH_S_REL;
            end
         end
         ps2h_pkg::OP_RECV: begin
            if (phase_ff == ps2h_pkg::PH_IDLE) begin
               shift_in = '0;
               count_in = '0;
               timer_in = '0;
               phase_in = ps2h_pkg::PH_R_SETTLE;
            end
         end
         ps2h_pkg::OP_TICK: begin
            prev_clock_in = req.clock_line;
            case (phase_ff)
               ps2h_pkg::PH_IDLE: ;
               ps2h_pkg::PH_S_REL,
               ps2h_pkg::PH_S_INH,
               ps2h_pkg::PH_S_RTS,
               ps2h_pkg::PH_R_SETTLE: begin
                  timer_in = delay_hit ? '0 : tick_inc;
                  if (delay_hit) begin
                     case (phase_ff)
                        ps2h_pkg::PH_S_REL: phase_in = ps2h_pkg::PH_S_INH;
                        ps2h_pkg::PH_S_INH: phase_in = ps2h_pkg::PH_S_RTS;
                        ps2h_pkg::PH_S_RTS: phase_in = ps2h_pkg::PH_S_WAIT;
                        default:            phase_in = ps2h_pkg::PH_R_WAIT;
                     endcase
                  end
               end
               ps2h_pkg::PH_S_WAIT: begin
                  if (!req.clock_line) begin
                     nodev_in = 1'b0;
                     timer_in = '0;
                     phase_in = ps2h_pkg::PH_S_BITS;
                  end else if (delay_hit) begin
                     timer_in = '0;
                     nodev_in = 1'b1;
                     sdone_in = 1'b1;
                     phase_in = ps2h_pkg::PH_IDLE;
                  end else begin
                     timer_in = tick_inc;
                  end
               end
               ps2h_pkg::PH_S_BITS: begin
                  if (fall) begin
                     if (count_ff < ps2h_pkg::BITS_PER_BYTE) begin
                        parity_in = parity_ff ^ shift_ff[0];
                        shift_in  = {1'b0, shift_ff[ps2h_pkg::BYTE_W-1:1]};
                        count_in  = count_inc;
                     end else begin
                        phase_in = ps2h_pkg::PH_S_ACKD;
                     end
                  end
               end
               ps2h_pkg::PH_S_ACKD: begin
                  if (!req.data_line) phase_in = ps2h_pkg::PH_S_ACKC;
               end
               ps2h_pkg::PH_S_ACKC: begin
                  if (!req.clock_line) phase_in = ps2h_pkg::PH_S_END;
               end
               ps2h_pkg::PH_S_END: begin
                  if (req.clock_line && req.data_line) begin
                     sdone_in = 1'b1;
                     phase_in = ps2h_pkg::PH_IDLE;
                  end
               end
               ps2h_pkg::PH_R_WAIT: begin
                  if (!req.clock_line) begin
                     timer_in = '0;
                     phase_in = ps2h_pkg::PH_R_HIGH;
                  end else if (delay_hit) begin
                     timer_in = '0;
                     rv_in    = 1'b1;
                     rto_in   = 1'b1;
                     phase_in = ps2h_pkg::PH_IDLE;
                  end else begin
                     timer_in = tick_inc;
                  end
               end
               ps2h_pkg::PH_R_HIGH: begin
                  if (req.clock_line) begin
                     count_in = '0;
                     phase_in = ps2h_pkg::PH_R_BITS;
                  end
               end
               ps2h_pkg::PH_R_BITS: begin
                  if (fall) begin
                     if (count_ff < ps2h_pkg::BITS_PER_BYTE) begin
                        shift_in = {req.data_line, shift_ff[ps2h_pkg::BYTE_W-1:1]};
                     end
                     count_in = count_inc;
                     if (count_inc >= ps2h_pkg::RX_FRAME_END) phase_in = ps2h_pkg::PH_R_TAIL;
                  end
               end
               ps2h_pkg::PH_R_TAIL: begin
                  if (req.clock_line) begin
                     rv_in    = 1'b1;
                     rbyte_in = shift_ff;
                     phase_in = ps2h_pkg::PH_IDLE;
                  end
               end
               default: phase_in = ps2h_pkg::PH_IDLE;
            endcase
         end
         default: ;
      endcase

      case (phase_in)
         ps2h_pkg::PH_S_INH:  begin cdl_in = 1'b1; ddl_in = 1'b0; end
         ps2h_pkg::PH_S_RTS:  begin cdl_in = 1'b1; ddl_in = 1'b1; end
         ps2h_pkg::PH_S_WAIT: begin cdl_in = 1'b0; ddl_in = 1'b1; end
         ps2h_pkg::PH_S_BITS: begin
            cdl_in = 1'b0;
            ddl_in = (count_in < ps2h_pkg::BITS_PER_BYTE) ? !shift_in[0] : !parity_in;
         end
         default: begin cdl_in = 1'b0; ddl_in = 1'b0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= ps2h_pkg::PH_IDLE;
         timer_ff      <= '0;
         shift_ff      <= '0;
         count_ff      <= '0;
         parity_ff     <= 1'b1;
         nodev_ff      <= 1'b0;
         prev_clock_ff <= 1'b1;
      end else if (accept) begin
         phase_ff      <= phase_in;
         timer_ff      <= timer_in;
         shift_ff      <= shift_in;
         count_ff      <= count_in;
         parity_ff     <= parity_in;
         nodev_ff      <= nodev_in;
         prev_clock_ff <= prev_clock_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response word
   always_ff @(posedge clock) begin
      if (accept) begin
         cdl_ff   <= cdl_in;
         ddl_ff   <= ddl_in;
         rv_ff    <= rv_in;
         rbyte_ff <= rbyte_in;
         rto_ff   <= rto_in;
         sdone_ff <= sdone_in;
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.clock_drive_low   = cdl_ff;
   assign rsp.data_drive_low    = ddl_ff;
   assign rsp.received_valid    = rv_ff;
   assign rsp.received_byte     = rbyte_ff;
   assign rsp.receive_timed_out = rto_ff;
   assign rsp.send_done         = sdone_ff;
   assign rsp.no_device         = nodev_ff;
   assign rsp.busy_res          = (phase_ff != ps2h_pkg::PH_IDLE);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.busy_res |-> !cdl_ff && !ddl_ff)
      else $error("line driven while idle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rto_ff |-> rv_ff && (rbyte_ff == '0))
      else $error("timeout without empty receive word");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (sdone_ff || rv_ff) |-> !rsp.busy_res && !(sdone_ff && rv_ff))
      else $error("sequence end while busy or both ends at once");

   assert property (@(posedge clock) disable iff (reset)
      phase_ff == ps2h_pkg::PH_S_BITS |-> count_ff <= ps2h_pkg::BITS_PER_BYTE)
      else $error("send bit count overrun");

   assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(phase_ff) && $stable(timer_ff))
      else $error("sequencer moved without an accepted word");

endmodule
`default_nettype wire
